>>> rtl/rs31_pkg.sv
// Shared types, constants and GF(2^5) helpers for the RS(31,29) code-offset decoder.
`timescale 1ns / 1ps

package rs31_pkg;

   localparam int SYM_W      = 5;
   localparam int CODE_LEN   = 31;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;
   localparam int STATUS_W   = 2;

   // Reduction term of x^5 = x^2 + 1.
   localparam logic [SYM_W-1:0] GF_POLY_LOW = 5'b00101;
   localparam logic [SYM_W-1:0] GF_ONE      = 5'd1;
   localparam logic [SYM_W-1:0] GF_ALPHA    = 5'd2;
   localparam logic [SYM_W-1:0] GF_ALPHA_SQ = 5'd4;
   localparam logic [SYM_W:0]   GF_ORDER    = 6'd31;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_CLEAN = 2'd0,
      STATUS_FIXED = 2'd1,
      STATUS_FAIL  = 2'd2
   } status_type;

   typedef struct packed {
      status_type       status;
      logic [SYM_W-1:0] err_pos;
      logic [SYM_W-1:0] err_val;
   } dec_result_type;

   // Shift-and-add multiply, reduce after each doubling.
   function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                               input logic [SYM_W-1:0] b);
      logic [SYM_W-1:0] acc;
      logic [SYM_W-1:0] sh;
      acc = '0;
      sh  = a;
      for (int i = 0; i < SYM_W; i++) begin
         if (b[i]) begin
            acc = acc ^ sh;
         end
         sh = {sh[SYM_W-2:0], 1'b0} ^ (sh[SYM_W-1] ? GF_POLY_LOW : '0);
      end
      return acc;
   endfunction

   // alpha^e for e in 0..30.
   function automatic logic [SYM_W-1:0] gf_exp(input logic [SYM_W-1:0] e);
      logic [SYM_W-1:0] v;
      unique case (e)
         5'd0:  v = 5'd1;   5'd1:  v = 5'd2;   5'd2:  v = 5'd4;   5'd3:  v = 5'd8;
         5'd4:  v = 5'd16;  5'd5:  v = 5'd5;   5'd6:  v = 5'd10;  5'd7:  v = 5'd20;
         5'd8:  v = 5'd13;  5'd9:  v = 5'd26;  5'd10: v = 5'd17;  5'd11: v = 5'd7;
         5'd12: v = 5'd14;  5'd13: v = 5'd28;  5'd14: v = 5'd29;  5'd15: v = 5'd31;
         5'd16: v = 5'd27;  5'd17: v = 5'd19;  5'd18: v = 5'd3;   5'd19: v = 5'd6;
         5'd20: v = 5'd12;  5'd21: v = 5'd24;  5'd22: v = 5'd21;  5'd23: v = 5'd15;
         5'd24: v = 5'd30;  5'd25: v = 5'd25;  5'd26: v = 5'd23;  5'd27: v = 5'd11;
         5'd28: v = 5'd22;  5'd29: v = 5'd9;   5'd30: v = 5'd18;
         default: v = 5'd1;
      endcase
      return v;
   endfunction

   // Discrete log of v for v in 1..31; zero maps to zero.
   function automatic logic [SYM_W-1:0] gf_log(input logic [SYM_W-1:0] v);
      logic [SYM_W-1:0] l;
      unique case (v)
         5'd0:  l = 5'd0;   5'd1:  l = 5'd0;   5'd2:  l = 5'd1;   5'd3:  l = 5'd18;
         5'd4:  l = 5'd2;   5'd5:  l = 5'd5;   5'd6:  l = 5'd19;  5'd7:  l = 5'd11;
         5'd8:  l = 5'd3;   5'd9:  l = 5'd29;  5'd10: l = 5'd6;   5'd11: l = 5'd27;
         5'd12: l = 5'd20;  5'd13: l = 5'd8;   5'd14: l = 5'd12;  5'd15: l = 5'd23;
         5'd16: l = 5'd4;   5'd17: l = 5'd10;  5'd18: l = 5'd30;  5'd19: l = 5'd17;
         5'd20: l = 5'd7;   5'd21: l = 5'd22;  5'd22: l = 5'd28;  5'd23: l = 5'd26;
         5'd24: l = 5'd21;  5'd25: l = 5'd25;  5'd26: l = 5'd9;   5'd27: l = 5'd16;
         5'd28: l = 5'd13;  5'd29: l = 5'd14;  5'd30: l = 5'd24;  5'd31: l = 5'd15;
         default: l = 5'd0;
      endcase
      return l;
   endfunction

endpackage

>>> rtl/rs31_cell.sv
// One storage cell of the symbol shift chain.
`timescale 1ns / 1ps

module rs31_cell
   import rs31_pkg::*;
(
   input  logic             clock,
   input  logic             shift_en,
   input  logic [SYM_W-1:0] nbr_sym,
   output logic [SYM_W-1:0] sym_out
);

   logic [SYM_W-1:0] sym_ff;
   logic [SYM_W-1:0] sym_in;

   // Take the neighbor's symbol on a shift, else hold.
   assign sym_in = shift_en ? nbr_sym : sym_ff;

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
   end

   assign sym_out = sym_ff;

endmodule

>>> rtl/rs31_decode.sv
// Single-error locator and value from the two syndromes, registered result.
`timescale 1ns / 1ps

module rs31_decode
   import rs31_pkg::*;
(
   input  logic             clock,
   input  logic             start,
   input  logic [SYM_W-1:0] syn_one,
   input  logic [SYM_W-1:0] syn_two,
   output dec_result_type   result
);

   dec_result_type   result_ff;
   dec_result_type   result_in;
   logic [SYM_W-1:0] log_one;
   logic [SYM_W-1:0] log_two;
   logic [SYM_W:0]   pos_sum;
   logic [SYM_W:0]   dbl_sum;
   logic [SYM_W:0]   dbl_mod;
   logic [SYM_W+1:0] val_sum;
   logic [SYM_W-1:0] pos_mod;
   logic [SYM_W-1:0] val_log;

   always_comb begin
      log_one = gf_log(syn_one);
      log_two = gf_log(syn_two);

      // Position: log(S2) - log(S1) mod 31.
      pos_sum = {1'b0, log_two} + GF_ORDER - {1'b0, log_one};
      pos_mod = (pos_sum >= GF_ORDER) ? SYM_W'(pos_sum - GF_ORDER) : SYM_W'(pos_sum);

      // Value: alpha^(2*log(S1) - log(S2)) mod 31.
      dbl_sum = {log_one, 1'b0};
      dbl_mod = (dbl_sum >= GF_ORDER) ? (dbl_sum - GF_ORDER) : dbl_sum;
      val_sum = {1'b0, dbl_mod} + {1'b0, GF_ORDER} - {2'b00, log_two};
      val_log = (val_sum >= {1'b0, GF_ORDER}) ? SYM_W'(val_sum - {1'b0, GF_ORDER})
                                             : SYM_W'(val_sum);

      result_in = result_ff;
      if (start) begin
         result_in.err_pos = pos_mod;
         result_in.err_val = gf_exp(val_log);
         priority if (syn_one == '0 && syn_two == '0) begin
            result_in.status = STATUS_CLEAN;
         end else if (syn_one != '0 && syn_two != '0) begin
            result_in.status = STATUS_FIXED;
         end else begin
            result_in.status = STATUS_FAIL;
         end
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

>>> rtl/rs31_code_offset_decoder_core.sv
// Top level of the RS(31,29) code-offset decoder: load chain, syndromes, control.
`timescale 1ns / 1ps

// Receives one frame of 31 transfers, each a noisy symbol and its sketch
// symbol, and returns 31 recovered symbols in arrival order, the noisy
// symbols with at most one symbol error corrected (t = 1 over GF(2^5),
// x^5+x^2+1). Both syndromes zero gives status 0 and unchanged symbols;
// both nonzero gives status 1 and the error removed; one zero gives
// status 2 and unchanged symbols. Status is the same on all 31 results and
// tlast marks the 31st. A frame passes through load, decode and emit
// states in that order: the single 31-cell symbol shift chain is
// filled and then drained through its head cell, so loading and
// emitting alternate. No input is taken while a frame is decoded or
// emitted. Output stalls simply hold the chain.
module rs31_code_offset_decoder_core
   import rs31_pkg::*;
#(
   parameter int CODE_LENGTH = CODE_LEN
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [4:0] noisy_symbol, [9:5] sketch_symbol, [15:10] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [4:0] recovered_symbol, [7:5] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // [1:0] decode_status
   output logic [STATUS_W-1:0]   rsp_tuser
);

   localparam int CNT_W = $clog2(CODE_LENGTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_LENGTH - 1);

   typedef enum logic [2:0] {
      ST_LOAD   = 3'b001,
      ST_DECODE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] pos_ff;
   logic [CNT_W-1:0] pos_in;
   logic [SYM_W-1:0] syn_one_ff;
   logic [SYM_W-1:0] syn_one_in;
   logic [SYM_W-1:0] syn_two_ff;
   logic [SYM_W-1:0] syn_two_in;
   logic [SYM_W-1:0] pow_one_ff;
   logic [SYM_W-1:0] pow_one_in;
   logic [SYM_W-1:0] pow_two_ff;
   logic [SYM_W-1:0] pow_two_in;

   logic             req_xfer;
   logic             rsp_xfer;
   logic             shift_en;
   logic [SYM_W-1:0] noisy_sym;
   logic [SYM_W-1:0] sketch_sym;
   logic [SYM_W-1:0] code_sym;
   logic [SYM_W-1:0] fix_mask;
   dec_result_type   dec_result;

   logic [SYM_W-1:0] chain_tap [CODE_LENGTH+1];

   assign noisy_sym  = req_tdata[SYM_W-1:0];
   assign sketch_sym = req_tdata[2*SYM_W-1:SYM_W];
   assign code_sym   = noisy_sym ^ sketch_sym;

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   // Advance the chain on every load or emit transfer; the tail takes the
   // new noisy symbol, the head holds the oldest one.
   assign shift_en = req_xfer || rsp_xfer;
   assign chain_tap[CODE_LENGTH] = noisy_sym;

   for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_cell
      rs31_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .nbr_sym  (chain_tap[i+1]),
         .sym_out  (chain_tap[i])
      );
   end

   // Latch the error location and status during the decode cycle.
   rs31_decode u_decode (
      .clock   (clock),
      .start   (state_ff == ST_DECODE),
      .syn_one (syn_one_ff),
      .syn_two (syn_two_ff),
      .result  (dec_result)
   );

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      syn_one_in = syn_one_ff;
      syn_two_in = syn_two_ff;
      pow_one_in = pow_one_ff;
      pow_two_in = pow_two_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               // Fold c_j * alpha^j and c_j * alpha^2j, then step the powers.
               syn_one_in = syn_one_ff ^ gf_mul(code_sym, pow_one_ff);
               syn_two_in = syn_two_ff ^ gf_mul(code_sym, pow_two_ff);
               pow_one_in = gf_mul(pow_one_ff, GF_ALPHA);
               pow_two_in = gf_mul(pow_two_ff, GF_ALPHA_SQ);
               if (pos_ff == CNT_LAST) begin
                  pos_in   = '0;
                  state_in = ST_DECODE;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_DECODE: begin
            // Syndromes are consumed this cycle; clear for the next frame.
            syn_one_in = '0;
            syn_two_in = '0;
            pow_one_in = GF_ONE;
            pow_two_in = GF_ONE;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               if (pos_ff == CNT_LAST) begin
                  pos_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
            pos_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         pos_ff     <= '0;
         syn_one_ff <= '0;
         syn_two_ff <= '0;
         pow_one_ff <= GF_ONE;
         pow_two_ff <= GF_ONE;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         syn_one_ff <= syn_one_in;
         syn_two_ff <= syn_two_in;
         pow_one_ff <= pow_one_in;
         pow_two_ff <= pow_two_in;
      end
   end

   // Apply the error value only at the located position of a corrected frame.
   assign fix_mask = (dec_result.status == STATUS_FIXED &&
                      pos_ff == CNT_W'(dec_result.err_pos)) ? dec_result.err_val : '0;

   assign rsp_tdata = RSP_DATA_W'(chain_tap[0] ^ fix_mask);
   assign rsp_tlast = (pos_ff == CNT_LAST);
   assign rsp_tuser = dec_result.status;

endmodule
